// ===== hdl/rvr_pkg.sv =====
// ---------------------------------------------------------------------------
// rvr_pkg: shared types and constants for the raster value reclassifier
// Payload structs for the cell/rule channel and the result channel, command,
// status and register codes, and the Q16.16 value width.
// ---------------------------------------------------------------------------
package rvr_pkg;

  // Q16.16 value width, fixed by the payload fields
  localparam int VALUE_BITS = 32;
  localparam int SLOT_BITS  = 4;
  localparam int COUNT_BITS = 5;
  localparam int STATUS_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;

  // -9999.0 in Q16.16
  localparam logic signed [VALUE_BITS-1:0] NODATA_RESET = -32'sd655294464;

  // Commands
  localparam logic CMD_CLASSIFY   = 1'b0;
  localparam logic CMD_WRITE_RULE = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_RECLASSIFIED = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_UNMATCHED    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_CELL_NODATA  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_MODE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_NODATA   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_NODATA = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RULE_COUNT    = 2'd3;

  typedef struct packed {
    logic                         cmd;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic [SLOT_BITS-1:0]         slot_index;
    logic signed [VALUE_BITS-1:0] bound_low;
    logic signed [VALUE_BITS-1:0] bound_high;
    logic signed [VALUE_BITS-1:0] class_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] out_value;
    logic [STATUS_BITS-1:0]       status;
    logic [SLOT_BITS-1:0]         hit_slot;
  } out_item_t;

endpackage

// ===== hdl/raster_value_reclassifier.sv =====
// ---------------------------------------------------------------------------
// raster_value_reclassifier: pipelined rule-table reclassifier
// Classifies Q16.16 cell values against up to MAX_RULES range or exact rules;
// rule-write items fill table slots and give no result.
// ---------------------------------------------------------------------------
//
//  channel   handshake                 payload      direction
//  -------   -----------------------   ----------   ---------
//  in        in_valid / in_ready       in_data      cells and rule writes in
//  out       out_valid / out_ready     out_data     one result per cell
//  cfg       cfg_wr_en                 cfg_index,   register writes
//                                      cfg_wdata
//
//  One item enters per cycle unless a held result stalls the pipe; a cell's
//  result passes the input stage, lane compare, priority encode, output register.
//  All stages advance together whenever the output register is empty or
//  being taken; a held result stalls the whole pipe with nothing lost.
//  Reset clears the valid bits and loads the register reset values; the
//  rule table is not cleared.
//  MAX_RULES may be 1 to 16 (slot_index and hit_slot are 4 bits).
//
module raster_value_reclassifier
  import rvr_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  // Configuration registers
  logic                         range_mode;
  logic signed [VALUE_BITS-1:0] cell_nodata;
  logic signed [VALUE_BITS-1:0] output_nodata;
  logic [COUNT_BITS-1:0]        rule_count;

  // Rule table: bounds are written as a rule leaves stage 1, class values as
  // it leaves stage 3, so each stage sees exactly the writes ahead of it.
  logic signed [VALUE_BITS-1:0] lower_bounds [MAX_RULES];
  logic signed [VALUE_BITS-1:0] upper_bounds [MAX_RULES];
  logic signed [VALUE_BITS-1:0] class_values [MAX_RULES];

  // Pipeline registers
  logic                         s1_valid;
  in_item_t                     s1_item;
  logic                         s2_valid;
  logic                         s2_cmd;
  logic [SLOT_BITS-1:0]         s2_slot;
  logic signed [VALUE_BITS-1:0] s2_class;
  logic                         s2_nodata;
  logic [MAX_RULES-1:0]         s2_match;
  logic                         s3_valid;
  logic                         s3_cmd;
  logic [SLOT_BITS-1:0]         s3_slot;
  logic signed [VALUE_BITS-1:0] s3_class;
  logic                         s3_nodata;
  logic                         s3_found;
  logic [IDX_W-1:0]             s3_idx;

  logic                         advance;
  logic                         s1_nodata;
  logic [MAX_RULES-1:0]         s1_match;
  logic                         s2_found;
  logic [IDX_W-1:0]             s2_idx;
  out_item_t                    s3_result;
  logic                         s1_slot_ok;
  logic                         s3_slot_ok;

  // Whole pipe moves when the output register is free or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode    <= 1'b1;
      cell_nodata   <= NODATA_RESET;
      output_nodata <= NODATA_RESET;
      rule_count    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RANGE_MODE:    range_mode    <= cfg_wdata[0];
        REG_CELL_NODATA:   cell_nodata   <= cfg_wdata;
        REG_OUTPUT_NODATA: output_nodata <= cfg_wdata;
        REG_RULE_COUNT:    rule_count    <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_data;
    end
  end

  // Stage 1 logic: one comparator lane per slot, gated by rule_count
  assign s1_nodata = (s1_item.cell_value == cell_nodata);

  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      if (COUNT_BITS'(i) < rule_count) begin
        if (range_mode) begin
          s1_match[i] = (lower_bounds[i] <= s1_item.cell_value) &&
                        (s1_item.cell_value <= upper_bounds[i]);
        end else begin
          s1_match[i] = (lower_bounds[i] == s1_item.cell_value);
        end
      end else begin
        s1_match[i] = 1'b0;
      end
    end
  end

  // Bounds are stored as a rule write leaves stage 1
  assign s1_slot_ok = ({1'b0, s1_item.slot_index} < (SLOT_BITS+1)'(MAX_RULES));

  always_ff @(posedge clk) begin
    if (advance && s1_valid && (s1_item.cmd == CMD_WRITE_RULE) && s1_slot_ok) begin
      lower_bounds[s1_item.slot_index[IDX_W-1:0]] <= s1_item.bound_low;
      upper_bounds[s1_item.slot_index[IDX_W-1:0]] <= s1_item.bound_high;
    end
  end

  // Stage 2: match vector
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd    <= s1_item.cmd;
      s2_slot   <= s1_item.slot_index;
      s2_class  <= s1_item.class_value;
      s2_nodata <= s1_nodata;
      s2_match  <= s1_match;
    end
  end

  // Stage 2 logic: lowest matching slot wins
  always_comb begin
    s2_found = |s2_match;
    s2_idx   = '0;
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (s2_match[i]) begin
        s2_idx = IDX_W'(i);
      end
    end
  end

  // Stage 3: encoded hit
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_cmd    <= s2_cmd;
      s3_slot   <= s2_slot;
      s3_class  <= s2_class;
      s3_nodata <= s2_nodata;
      s3_found  <= s2_found;
      s3_idx    <= s2_idx;
    end
  end

  // Class values are stored as a rule write leaves stage 3
  assign s3_slot_ok = ({1'b0, s3_slot} < (SLOT_BITS+1)'(MAX_RULES));

  always_ff @(posedge clk) begin
    if (advance && s3_valid && (s3_cmd == CMD_WRITE_RULE) && s3_slot_ok) begin
      class_values[s3_slot[IDX_W-1:0]] <= s3_class;
    end
  end

  // Stage 3 logic: nodata first, then the winning rule, else unmatched
  always_comb begin
    priority if (s3_nodata) begin
      s3_result.out_value = output_nodata;
      s3_result.status    = STATUS_CELL_NODATA;
      s3_result.hit_slot  = '0;
    end else if (s3_found) begin
      s3_result.out_value = class_values[s3_idx];
      s3_result.status    = STATUS_RECLASSIFIED;
      s3_result.hit_slot  = SLOT_BITS'(s3_idx);
    end else begin
      s3_result.out_value = output_nodata;
      s3_result.status    = STATUS_UNMATCHED;
      s3_result.hit_slot  = '0;
    end
  end

  // Output register: only classify items give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid && (s3_cmd == CMD_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= s3_result;
    end
  end

endmodule

// ===== bench/tb_raster_value_reclassifier.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_raster_value_reclassifier: self-checking bench for the reclassifier
// Drives cell and rule-write transfers with random gaps, throttles the result
// side, predicts every result from a local copy of the rule table and the
// registers, and checks each result transfer field by field in order.
// ---------------------------------------------------------------------------
module tb_raster_value_reclassifier;
  import rvr_pkg::*;

  localparam int RULE_SLOTS   = 16;
  localparam int PIPE_SETTLE  = 8;     // covers the pipe with margin
  localparam int PHASE_ITEMS  = 150;
  localparam int PHASES       = 8;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_TRIGGER = 60;

  localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7FFF_FFFF;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [VALUE_BITS-1:0]     cfg_wdata = '0;

  // Predictor state: rule table and register copies
  logic signed [VALUE_BITS-1:0] rule_low   [RULE_SLOTS];
  logic signed [VALUE_BITS-1:0] rule_high  [RULE_SLOTS];
  logic signed [VALUE_BITS-1:0] rule_class [RULE_SLOTS];
  logic                         mode_range = 1'b1;
  logic [VALUE_BITS-1:0]        nodata_in  = NODATA_RESET;
  logic [VALUE_BITS-1:0]        nodata_out = NODATA_RESET;
  logic [COUNT_BITS-1:0]        rules_used = '0;

  in_item_t  tx_items[$];            // items waiting for the driver
  out_item_t expected_classes[$];    // predicted results, oldest first

  int unsigned errors = 0;
  int unsigned results_seen = 0;

  raster_value_reclassifier #(.MAX_RULES(RULE_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Apply one accepted item to the rule table, or queue its predicted result
  function automatic void reclassify(input in_item_t it);
    out_item_t res;
    int        lim;
    bit        hit;
    if (it.cmd == CMD_WRITE_RULE) begin
      rule_low[it.slot_index]   = it.bound_low;
      rule_high[it.slot_index]  = it.bound_high;
      rule_class[it.slot_index] = it.class_value;
      return;
    end
    res.out_value = nodata_out;
    res.status    = STATUS_UNMATCHED;
    res.hit_slot  = '0;
    if (it.cell_value == nodata_in) begin
      // nodata wins over any rule
      res.status = STATUS_CELL_NODATA;
    end else begin
      lim = (rules_used > RULE_SLOTS) ? RULE_SLOTS : int'(rules_used);
      hit = 1'b0;
      for (int i = 0; i < lim && !hit; i++) begin
        if (mode_range) begin
          hit = ($signed(rule_low[i]) <= $signed(it.cell_value)) &&
                ($signed(it.cell_value) <= $signed(rule_high[i]));
        end else begin
          hit = (rule_low[i] == it.cell_value);
        end
        if (hit) begin
          res.out_value = rule_class[i];
          res.status    = STATUS_RECLASSIFIED;
          res.hit_slot  = SLOT_BITS'(i);
        end
      end
    end
    expected_classes = {expected_classes, res};
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return 32'd1;
    endcase
  endfunction

  // Cell transfer; the rule fields carry junk the block must ignore
  task automatic push_cell(input logic [VALUE_BITS-1:0] value);
    in_item_t it;
    it.cmd         = CMD_CLASSIFY;
    it.cell_value  = value;
    it.slot_index  = SLOT_BITS'($urandom());
    it.bound_low   = $urandom();
    it.bound_high  = $urandom();
    it.class_value = $urandom();
    tx_items = {tx_items, it};
  endtask

  task automatic push_rule(input logic [SLOT_BITS-1:0] slot,
                           input logic [VALUE_BITS-1:0] lo,
                           input logic [VALUE_BITS-1:0] hi,
                           input logic [VALUE_BITS-1:0] cls);
    in_item_t it;
    it.cmd         = CMD_WRITE_RULE;
    it.cell_value  = $urandom();
    it.slot_index  = slot;
    it.bound_low   = lo;
    it.bound_high  = hi;
    it.class_value = cls;
    tx_items = {tx_items, it};
  endtask

  // One random item, biased toward values that hit rule edges
  task automatic gen_item();
    int unsigned           r;
    int unsigned           k;
    int                    lim;
    logic [SLOT_BITS-1:0]  s;
    logic [VALUE_BITS-1:0] c;
    logic [VALUE_BITS-1:0] w;
    lim = (rules_used > RULE_SLOTS) ? RULE_SLOTS : int'(rules_used);
    s = (lim != 0 && $urandom_range(0, 3) != 0) ?
        SLOT_BITS'($urandom_range(0, lim - 1)) : SLOT_BITS'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    c = $urandom();
    if (r < 25) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        push_rule(s, c, c + $urandom_range(0, 1 << 17), $urandom());
      end else if (k < 55) begin
        // reversed interval
        w = $urandom_range(1, 1 << 20);
        push_rule(s, c, c - w, $urandom());
      end else if (k < 70) begin
        push_rule(s, pick_extreme(), pick_extreme(), pick_extreme());
      end else begin
        push_rule(s, $urandom(), $urandom(), $urandom());
      end
    end else begin
      k = $urandom_range(0, 99);
      if (k < 10)      push_cell(nodata_in);
      else if (k < 40) push_cell(rule_low[s]);
      else if (k < 55) push_cell(rule_high[s]);
      else if (k < 60) push_cell(rule_low[s] - 1);
      else if (k < 65) push_cell(rule_high[s] + 1);
      else if (k < 75) push_cell(pick_extreme());
      else if (k < 80) push_cell(nodata_in ^ (32'd1 << $urandom_range(0, 31)));
      else             push_cell(c);
    end
  endtask

  // Wait until nothing is queued, in flight or expected
  task automatic wait_idle();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || expected_classes.size() != 0);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [VALUE_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RANGE_MODE:    mode_range = val[0];
      REG_CELL_NODATA:   nodata_in  = val;
      REG_OUTPUT_NODATA: nodata_out = val;
      REG_RULE_COUNT:    rules_used = val[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers; unused upper bits carry junk
  task automatic load_config(input logic mode, input logic [VALUE_BITS-1:0] nd_in,
                             input logic [VALUE_BITS-1:0] nd_out,
                             input logic [COUNT_BITS-1:0] count);
    logic [VALUE_BITS-1:0] junk;
    junk = $urandom();
    cfg_write(REG_RANGE_MODE, {junk[VALUE_BITS-1:1], mode});
    cfg_write(REG_CELL_NODATA, nd_in);
    cfg_write(REG_OUTPUT_NODATA, nd_out);
    cfg_write(REG_RULE_COUNT, {junk[VALUE_BITS-1:COUNT_BITS], count});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: one transfer at a time from tx_items, random gaps between them
  always @(posedge clk) begin : drive
    int unsigned r;
    int unsigned tx_gap;
    int unsigned tx_quiet;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   = 0;
      tx_quiet = 0;
    end else begin
      if (in_valid && in_ready) reclassify(in_data);
      if (!(in_valid && !in_ready)) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (tx_items.size() != 0) begin
          in_data  <= tx_items.pop_front();
          in_valid <= 1'b1;
          if (tx_quiet != 0) begin
            tx_quiet--;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 55)      tx_gap = 0;
            else if (r < 88) tx_gap = $urandom_range(1, 3);
            else if (r < 96) tx_gap = $urandom_range(4, 8);
            else if (r < 98) tx_gap = $urandom_range(15, 40);
            else             tx_quiet = 60;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result transfers and throttle out_ready
  always @(posedge clk) begin : watch
    out_item_t   want;
    int unsigned r;
    int unsigned rx_stall;
    int unsigned rx_quiet;
    bit          long_hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall       = 0;
      rx_quiet       = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_classes.size() == 0) begin
          $error("unexpected result: out_value %0d status %0d hit_slot %0d",
                 out_data.out_value, out_data.status, out_data.hit_slot);
          errors++;
        end else begin
          want = expected_classes.pop_front();
          if (out_data.out_value !== want.out_value) begin
            $error("out_value: expected %0d, actual %0d", want.out_value,
                   out_data.out_value);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.hit_slot !== want.hit_slot) begin
            $error("hit_slot: expected %0d, actual %0d", want.hit_slot,
                   out_data.hit_slot);
            errors++;
          end
        end
        results_seen++;
      end
      // one long hold-off so the pipe fills and in_ready drops
      if (!long_hold_done && results_seen >= HOLD_TRIGGER) begin
        rx_stall       = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (rx_stall == 0) begin
        if (rx_quiet != 0) begin
          rx_quiet--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 8)       rx_stall = $urandom_range(1, 3);
          else if (r < 9)  rx_stall = $urandom_range(10, 40);
          else if (r < 11) rx_quiet = 50;
        end
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, no rules in use
    push_cell($urandom());
    push_cell(NODATA_RESET);

    // Fill every slot before any is examined
    push_rule(4'd0, VAL_MIN, VAL_MIN, VAL_MAX);
    push_rule(4'd1, VAL_MAX, VAL_MAX, VAL_MIN);
    push_rule(4'd2, 32'd100, -32'sd100, 32'd5);           // reversed, never hits
    push_rule(4'd3, -32'sd65536, 32'sd65536, 32'd1);
    push_rule(4'd4, 32'd0, VAL_MAX, 32'd2);               // overlaps slot 3
    push_rule(4'd5, VAL_MIN + 1, -32'sd1, 32'd3);         // covers the nodata value
    for (int i = 6; i < RULE_SLOTS; i++) begin
      automatic logic [VALUE_BITS-1:0] base = $urandom();
      push_rule(SLOT_BITS'(i), base, base + $urandom_range(0, 1 << 16), $urandom());
    end
    wait_idle();
    load_config(1'b1, NODATA_RESET, NODATA_RESET, 5'd16);

    push_cell(VAL_MIN);
    push_cell(VAL_MAX);
    push_cell(32'd0);
    push_cell(32'sd65536);
    push_cell(32'sd65537);
    push_cell(NODATA_RESET);
    push_cell(-32'sd65537);
    wait_idle();

    // Random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_config(1'b0, $urandom(), $urandom(), 5'd31);
        1: load_config(1'b1, VAL_MIN, VAL_MAX, 5'd16);
        2: load_config(1'b0, VAL_MAX, VAL_MIN, 5'd1);
        3: load_config(1'b1, '0, '0, 5'd0);
        default: load_config(1'($urandom()),
                             ($urandom_range(0, 1) != 0) ? rule_low[$urandom_range(0, 15)]
                                                         : $urandom(),
                             $urandom(), COUNT_BITS'($urandom_range(0, 31)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) gen_item();
      wait_idle();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
